FILE: hw/rtl/bmls_pkg.sv
// Package for the bigram letter sampler: default sizes, transfer types and
// the sequencer state type. Depends on nothing; the top level imports it.

package bmls_pkg;

  localparam int SYMBOLS_DEF     = 28;
  localparam int MAX_LETTERS_DEF = 20;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int RND_BITS        = 31;

  typedef struct packed {
    logic        kind;
    logic [4:0]  prev_symbol;
    logic [4:0]  next_symbol;
    logic [23:0] count_value;
    logic [30:0] random_value;
  } item_t;

  typedef struct packed {
    logic [4:0] symbol;
    logic       word_end;
    logic       error;
  } result_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_TOTAL,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FIN,
    ST_RESULT
  } state_t;

endpackage

FILE: hw/rtl/bmls_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.

module bmls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 784
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bigram_markov_letter_sampler.sv
// Top level of the bigram letter sampler: sequencer, row totals, a
// compare-and-subtract unit and the count memory. Depends on bmls_pkg, bmls_ram.

// After reset the block clears the count memory, one address at a time over all
// SYMBOLS*SYMBOLS entries (784 by default), with item_stall high. A load reads
// the old count and then writes the new one. A draw with a zero row total goes
// straight to its result; otherwise the bit-serial remainder unit runs first,
// then the row is scanned through the memory's one read port, each column read
// and then checked, until a column is picked. One item is worked on at a time; a
// finished result waits in the output register while the next item is taken.

module bigram_markov_letter_sampler import bmls_pkg::*; #(
  parameter int SYMBOLS     = SYMBOLS_DEF,
  parameter int MAX_LETTERS = MAX_LETTERS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int SYM_W    = $clog2(SYMBOLS);
  localparam int DEPTH    = SYMBOLS * SYMBOLS;
  localparam int AW       = $clog2(DEPTH);
  localparam int SUM_BITS = COUNT_BITS + $clog2(SYMBOLS);
  localparam int RW       = (SUM_BITS > RND_BITS) ? SUM_BITS + 1 : RND_BITS + 1;
  localparam int CNT_W    = $clog2(RND_BITS);
  localparam logic [SYM_W-1:0] START_SYM = SYM_W'(SYMBOLS - 2);
  localparam logic [SYM_W-1:0] END_SYM   = SYM_W'(SYMBOLS - 1);
  localparam logic [SYM_W-1:0] LAST_COL  = SYM_W'(SYMBOLS - 1);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(RND_BITS - 1);

  state_t state, state_next;

  logic [SUM_BITS-1:0] row_sums [SYMBOLS];
  item_t               it;
  logic [SYM_W-1:0]    cur;
  logic [4:0]          wlen;
  logic [SYM_W-1:0]    sum_idx;
  logic [SUM_BITS-1:0] total;
  logic [RW-1:0]       rem;
  logic [RND_BITS-1:0] rnd_sh;
  logic [CNT_W-1:0]    bit_cnt;
  logic [SYM_W-1:0]    col;
  logic [SUM_BITS-1:0] run;
  logic [SYM_W-1:0]    pick;
  logic [AW-1:0]       clr_addr;
  result_t             res;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  logic                  accept, slot_free, in_range;
  logic [COUNT_BITS-1:0] load_val;
  logic [SUM_BITS-1:0]   sum_rd, run_next;
  logic [RW-1:0]         div_sh, total_ext, div_diff;
  logic                  div_ge, hit;
  logic [4:0]            wlen_inc;

  assign accept    = item_valid && !item_stall;
  assign slot_free = !result_valid || !result_stall;
  assign in_range  = (32'(item.prev_symbol) < SYMBOLS) && (32'(item.next_symbol) < SYMBOLS);
  assign load_val  = COUNT_BITS'(it.count_value);
  assign sum_rd    = row_sums[sum_idx];
  assign total_ext = RW'(total);
  assign div_sh    = {rem[RW-2:0], rnd_sh[RND_BITS-1]};
  assign div_diff  = div_sh - total_ext;
  assign div_ge    = div_sh >= total_ext;
  assign run_next  = run + SUM_BITS'(ram_rdata);
  assign hit       = rem < RW'(run_next);
  assign wlen_inc  = wlen + 5'd1;
  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = AW'(it.prev_symbol) * AW'(SYMBOLS) + AW'(it.next_symbol);
    ram_wdata  = load_val;
    ram_raddr  = ram_waddr;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (item.kind == KIND_DRAW) state_next = ST_TOTAL;
          else if (in_range) state_next = ST_LD_RD;
        end
      end
      ST_LD_RD: state_next = ST_LD_WR;
      ST_LD_WR: begin
        ram_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_TOTAL: begin
        if (sum_rd == '0) state_next = ST_RESULT;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (bit_cnt == LAST_BIT) state_next = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        ram_raddr  = AW'(cur) * AW'(SYMBOLS) + AW'(col);
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (hit || col == LAST_COL) state_next = ST_FIN;
        else state_next = ST_SCAN_RD;
      end
      ST_FIN: state_next = ST_RESULT;
      ST_RESULT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      cur          <= START_SYM;
      wlen         <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < SYMBOLS; i++) row_sums[i] <= '0;
    end else begin
      if (state == ST_RESULT && slot_free) begin
        result       <= res;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        ST_IDLE: begin
          if (accept) begin
            it      <= item;
            sum_idx <= (item.kind == KIND_DRAW) ? cur : SYM_W'(item.prev_symbol);
          end
        end
        ST_LD_WR: begin
          row_sums[sum_idx] <= sum_rd - SUM_BITS'(ram_rdata) + SUM_BITS'(load_val);
        end
        ST_TOTAL: begin
          total   <= sum_rd;
          rem     <= '0;
          rnd_sh  <= it.random_value;
          bit_cnt <= '0;
          col     <= '0;
          run     <= '0;
          if (sum_rd == '0) begin
            if (wlen == '0) begin
              res <= '{symbol: 5'd0, word_end: 1'b0, error: 1'b1};
            end else begin
              res  <= '{symbol: 5'(END_SYM), word_end: 1'b1, error: 1'b0};
              cur  <= START_SYM;
              wlen <= '0;
            end
          end
        end
        ST_DIV: begin
          rem     <= div_ge ? div_diff : div_sh;
          rnd_sh  <= {rnd_sh[RND_BITS-2:0], 1'b0};
          bit_cnt <= bit_cnt + CNT_W'(1);
        end
        ST_SCAN_CHK: begin
          run <= run_next;
          if (hit) begin
            pick    <= col;
            sum_idx <= col;
          end else if (col == LAST_COL) begin
            pick    <= END_SYM;
            sum_idx <= END_SYM;
          end else begin
            col <= col + SYM_W'(1);
          end
        end
        ST_FIN: begin
          if (pick == END_SYM || wlen_inc >= 5'(MAX_LETTERS) || sum_rd == '0) begin
            res  <= '{symbol: 5'(pick), word_end: 1'b1, error: 1'b0};
            cur  <= START_SYM;
            wlen <= '0;
          end else begin
            res  <= '{symbol: 5'(pick), word_end: 1'b0, error: 1'b0};
            cur  <= pick;
            wlen <= wlen_inc;
          end
        end
        default: ;
      endcase
    end
  end

  bmls_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_rem_below_total: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |=> rem < total_ext)
    else $error("remainder not below row total");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> 32'(cur) < SYMBOLS)
    else $error("current symbol out of range");

  a_fin_to_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |=> state == ST_RESULT)
    else $error("finish step did not hand over a result");

endmodule
